/* rtl/core/sliding_window_median_macros.svh */
// assertion macros shared by the sliding window median rtl
// no dependencies; included by files that carry assertions
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/swm_pkg.sv */
// types and constants for the sliding window median filter
// no dependencies; imported by every module of the block
package swm_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int IDX_BITS    = $clog2(MAX_WINDOW);
   localparam int WIN_BITS    = IDX_BITS + 1;
   localparam int SAMPLE_BITS = 32;
   localparam int MEDIAN_BITS = SAMPLE_BITS + 1;

   localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(3);
   localparam logic [WIN_BITS-1:0] WIN_MAX   = WIN_BITS'(MAX_WINDOW);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [MEDIAN_BITS-1:0] median_type;

   // what a cell shows its neighbors
   typedef struct packed {
      sample_type          val;
      logic [IDX_BITS-1:0] age;
      logic                gt;
   } link_type;

endpackage

/* rtl/core/swm_cell.sv */
// one sorted cell: holds a sample and its age, takes from either neighbor or the new sample
// depends on swm_pkg
module swm_cell
   import swm_pkg::*;
(
   input  logic                clock,
   input  logic                step,
   input  sample_type          sample,
   input  logic                valid,
   input  logic                full,
   input  logic [IDX_BITS-1:0] win_last,
   input  link_type            prev_link,
   input  link_type            next_link,
   input  logic                prev_shift,
   input  logic                shift,
   output link_type            link,
   output logic                del
);

   sample_type          val_ff, val_in;
   logic [IDX_BITS-1:0] age_ff, age_in;
   sample_type          a_val, b_val;
   logic [IDX_BITS-1:0] a_age, b_age;
   logic                a_gt, b_gt;

   assign link.val = val_ff;
   assign link.age = age_ff;
   assign link.gt  = !valid || (val_ff > sample);
   assign del      = valid && full && (age_ff == win_last);

   always_comb begin
      // slot after removal of the oldest word
      if (shift) begin
         a_val = next_link.val;
         a_age = next_link.age;
         a_gt  = next_link.gt;
      end else begin
         a_val = val_ff;
         a_age = age_ff;
         a_gt  = link.gt;
      end
      // slot below, after removal
      if (prev_shift) begin
         b_val = val_ff;
         b_age = age_ff;
         b_gt  = link.gt;
      end else begin
         b_val = prev_link.val;
         b_age = prev_link.age;
         b_gt  = prev_link.gt;
      end
      if (!a_gt) begin
         val_in = a_val;
         age_in = a_age + IDX_BITS'(1);
      end else if (!b_gt) begin
         val_in = sample;
         age_in = '0;
      end else begin
         val_in = b_val;
         age_in = b_age + IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

endmodule

/* rtl/core/swm_chain.sv */
// row of sorted cells with removal of the oldest word and ordered insert
// depends on swm_pkg, swm_cell and the assertion macros
`include "sliding_window_median_macros.svh"

module swm_chain
   import swm_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  sample_type                     sample,
   input  logic [WIN_BITS-1:0]            fill,
   input  logic                           full,
   input  logic [IDX_BITS-1:0]            win_last,
   output sample_type [MAX_WINDOW-1:0]    cell_val
);

   link_type                links [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]   del_vec;
   logic [MAX_WINDOW-1:0]   shift_vec;
   logic [MAX_WINDOW-1:0]   valid_vec;

   // cells at and above the removed one take from above
   assign shift_vec = (del_vec == '0) ? '0 : ~(del_vec - MAX_WINDOW'(1));

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      localparam logic [WIN_BITS-1:0] POS = WIN_BITS'(i);
      link_type prev_link, next_link;
      logic     prev_shift;

      assign valid_vec[i] = POS < fill;
      assign cell_val[i]  = links[i].val;

      if (i == 0) begin : g_bottom
         assign prev_link  = '{val: '0, age: '0, gt: 1'b0};
         assign prev_shift = 1'b0;
      end else begin : g_mid_lo
         assign prev_link  = links[i-1];
         assign prev_shift = shift_vec[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_top
         assign next_link = '{val: '0, age: '0, gt: 1'b1};
      end else begin : g_mid_hi
         assign next_link = links[i+1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .step       (step),
         .sample     (sample),
         .valid      (valid_vec[i]),
         .full       (full),
         .win_last   (win_last),
         .prev_link  (prev_link),
         .next_link  (next_link),
         .prev_shift (prev_shift),
         .shift      (shift_vec[i]),
         .link       (links[i]),
         .del        (del_vec[i])
      );
   end

   `SWM_ASSERT_NOW(a_one_removal, clock, reset, 1'b1, $onehot0(del_vec), "two cells removed")
   `SWM_ASSERT_NOW(a_full_removes, clock, reset, step && full, $onehot(del_vec),
                   "full window without oldest word")
   `SWM_ASSERT_NEXT(a_empty_insert, clock, reset, step && (fill == '0),
                    links[0].val == $past(sample), "first word not at bottom")

endmodule

/* rtl/core/sliding_window_median.sv */
// sliding window median filter, top level: window control and output stage
// depends on swm_pkg, swm_chain and the assertion macros
//
//   port group   dir  handshake          payload
//   req_         in   req_valid/stall    req_sample, req_restart
//   rsp_         out  rsp_valid/stall    rsp_median_doubled
//   csr_         in   csr_wr_en          csr_wr_data (window size)
//
// one word accepted per cycle while req_stall is low; the cell row sorts it in a single update
// a median follows its word through the cell update, then the mux and add into median_ff
// reset sets window size 3 and an empty window; no clearing pass
// a stalled output holds one pending median, then req_stall rises
`include "sliding_window_median_macros.svh"

module sliding_window_median
   import swm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sample_type            req_sample,
   input  logic                  req_restart,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output median_type            rsp_median_doubled,
   input  logic                  csr_wr_en,
   input  logic [WIN_BITS-1:0]   csr_wr_data
);

   logic [WIN_BITS-1:0]        win_ff, win_in;
   logic [WIN_BITS-1:0]        fill_ff, fill_in;
   logic                       pend_ff, pend_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   median_type                 median_ff, median_in;
   logic [WIN_BITS-1:0]        fill_base;
   logic                       full, produce, acc, move;
   logic [IDX_BITS-1:0]        win_last, lo_idx, hi_idx;
   sample_type [MAX_WINDOW-1:0] cell_val;
   logic [WIN_BITS-1:0]        csr_sat;
   logic [WIN_BITS-1:0]        win_m1;

   assign csr_sat = (csr_wr_data == '0) ? WIN_BITS'(1) :
                    (csr_wr_data > WIN_MAX) ? WIN_MAX : csr_wr_data;

   assign move      = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pend_ff && !move;
   assign acc       = req_valid && !req_stall;

   assign fill_base = req_restart ? '0 : fill_ff;
   assign full      = fill_base >= win_ff;
   assign produce   = full || ((fill_base + WIN_BITS'(1)) == win_ff);
   assign win_m1    = win_ff - WIN_BITS'(1);
   assign win_last  = win_m1[IDX_BITS-1:0];
   assign lo_idx    = win_m1[WIN_BITS-1:1];
   assign hi_idx    = win_ff[WIN_BITS-1:1];

   assign median_in = MEDIAN_BITS'(cell_val[lo_idx]) + MEDIAN_BITS'(cell_val[hi_idx]);

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (csr_wr_en) begin
         win_in  = csr_sat;
         fill_in = '0;
      end else if (acc) begin
         fill_in = full ? fill_base : fill_base + WIN_BITS'(1);
      end
      if (acc) begin
         pend_in = produce;
      end else begin
         pend_in = pend_ff && !move;
      end
      rsp_valid_in = move || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= WIN_RESET;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         median_ff <= median_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = median_ff;

   swm_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .step     (acc),
      .sample   (req_sample),
      .fill     (fill_base),
      .full     (full),
      .win_last (win_last),
      .cell_val (cell_val)
   );

   `SWM_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= win_ff, "fill above window")
   `SWM_ASSERT_NEXT(a_produce_pend, clock, reset, acc && produce, pend_ff,
                    "median not queued")
   `SWM_ASSERT_NEXT(a_pend_hold, clock, reset, pend_ff && !move,
                    pend_ff && $stable(fill_ff), "pending median lost")

endmodule
